// ----- hw/rtl/tbpc_pkg.sv -----
// Package for the two-button press classifier.
// Holds the item structs, the event and register codes, widths and the counter helper.
// Depends on nothing; every module of the block imports it.
package tbpc_pkg;

  // Width of the hold and blink counters.
  localparam int unsigned CountWidth = 16;
  // Width of every configuration register.
  localparam int unsigned CfgWidth = 16;
  // Common width used when a counter is compared against a threshold.
  localparam int unsigned CmpWidth = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;
  // Width of the configuration register index.
  localparam int unsigned CfgIdxWidth = 3;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [CfgWidth-1:0]   cfg_word_t;
  typedef logic [CmpWidth-1:0]   cmp_t;

  typedef enum logic [2:0] {
    EvNone   = 3'd0,
    EvAShort = 3'd1,
    EvALong  = 3'd2,
    EvBShort = 3'd3,
    EvBLong  = 3'd4
  } press_event_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegShortMin   = 3'd0,
    RegShortMax   = 3'd1,
    RegLongMin    = 3'd2,
    RegBShortMin  = 3'd3,
    RegBlinkHalf  = 3'd4
  } cfg_reg_e;

  localparam cfg_word_t ShortMinReset  = 16'd25;
  localparam cfg_word_t ShortMaxReset  = 16'd300;
  localparam cfg_word_t LongMinReset   = 16'd2000;
  localparam cfg_word_t BShortMinReset = 16'd15;
  localparam cfg_word_t BlinkHalfReset = 16'd500;

  typedef struct packed {
    logic btn_a_level;
    logic btn_b_level;
    logic blink_enable;
  } in_item_t;

  typedef struct packed {
    press_event_e press_event;
    logic         display_run;
    logic         display_blank;
  } out_item_t;

  // Increment that stops at the largest counter value.
  function automatic count_t count_up(input count_t c);
    count_t r;
    r = (c == {CountWidth{1'b1}}) ? c : c + count_t'(1);
    return r;
  endfunction

  function automatic cmp_t cnt_ext(input count_t c);
    cmp_t r;
    r = cmp_t'(c);
    return r;
  endfunction

  function automatic cmp_t cfg_ext(input cfg_word_t c);
    cmp_t r;
    r = cmp_t'(c);
    return r;
  endfunction

endpackage

// ----- hw/rtl/two_button_press_classifier.sv -----
// Top level of the two-button press classifier with display blink control.
// Depends on tbpc_pkg for the item structs, codes, widths and counter helper.
//
// Each input item is one timer tick carrying two active-low button levels and a
// blink-enable bit; each tick yields exactly one result item with a press event
// (none, A short, A long, B short, B long), the display run flag after the tick
// and a one-tick blank pulse. The block takes one item per clock cycle while
// in_ready_o is high: all counting and threshold compares happen in a single
// pass of logic when an item is accepted, and the result is stored in the
// output register. That output register lets a new item be accepted in the same
// cycle the previous result is taken, so the sustained rate is one item per
// cycle whenever the downstream side keeps out_ready_i high. The five 16-bit
// thresholds are written through a plain write port (index 0 short min, 1 short
// max, 2 long min, 3 B short min, 4 blink half period) and should only be
// changed while the block is idle. Counters saturate instead of wrapping.
module two_button_press_classifier (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [tbpc_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [tbpc_pkg::CfgWidth-1:0]          cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  tbpc_pkg::in_item_t                     in_item_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output tbpc_pkg::out_item_t                    out_item_o
);
  import tbpc_pkg::*;

  // Configuration registers.
  cfg_word_t short_min_q, short_max_q, long_min_q, b_short_min_q, blink_half_q;

  // Tick state.
  count_t hold_a_q, hold_a_d;
  count_t hold_b_q, hold_b_d;
  count_t blink_cnt_q, blink_cnt_d;
  logic   blink_phase_q, blink_phase_d;
  logic   run_q, run_d;

  // Output register.
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  logic accept;
  logic a_pressed, b_pressed;
  logic blink_wrap, blank;
  logic chk_a_short, chk_a_long, chk_b_short, chk_b_long;
  press_event_e ev;
  count_t blink_after_wrap, hold_a_mid, hold_b_mid;

  // The output register frees up in the same cycle its item is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q   <= ShortMinReset;
      short_max_q   <= ShortMaxReset;
      long_min_q    <= LongMinReset;
      b_short_min_q <= BShortMinReset;
      blink_half_q  <= BlinkHalfReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegShortMin:  short_min_q   <= cfg_data_i;
        RegShortMax:  short_max_q   <= cfg_data_i;
        RegLongMin:   long_min_q    <= cfg_data_i;
        RegBShortMin: b_short_min_q <= cfg_data_i;
        RegBlinkHalf: blink_half_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    a_pressed = !in_item_i.btn_a_level;
    b_pressed = !in_item_i.btn_b_level;

    // Blink step: a count past the half period flips the phase. Entering
    // phase one stops the display and blanks it; phase zero restarts it.
    blink_wrap       = cnt_ext(blink_cnt_q) > cfg_ext(blink_half_q);
    blink_phase_d    = blink_phase_q ^ blink_wrap;
    blink_after_wrap = blink_wrap ? '0 : blink_cnt_q;
    run_d            = blink_wrap ? !blink_phase_d : run_q;
    blank            = blink_wrap && blink_phase_d;
    if (in_item_i.blink_enable) begin
      blink_cnt_d = count_up(blink_after_wrap);
    end else begin
      blink_cnt_d = blink_after_wrap;
      run_d       = 1'b1;
    end

    // Press checks; a later check wins the event for this tick.
    chk_a_short = !a_pressed && (cnt_ext(hold_a_q) > cfg_ext(short_min_q))
                  && (cnt_ext(hold_a_q) < cfg_ext(short_max_q));
    chk_a_long  = a_pressed && (cnt_ext(hold_a_q) > cfg_ext(long_min_q));
    chk_b_short = !b_pressed && (cnt_ext(hold_b_q) > cfg_ext(b_short_min_q));
    chk_b_long  = b_pressed && (cnt_ext(hold_b_q) > cfg_ext(long_min_q));

    if (chk_b_long) begin
      ev = EvBLong;
    end else if (chk_b_short) begin
      ev = EvBShort;
    end else if (chk_a_long) begin
      ev = EvALong;
    end else if (chk_a_short) begin
      ev = EvAShort;
    end else begin
      ev = EvNone;
    end

    hold_a_mid = (chk_a_short || chk_a_long) ? '0 : hold_a_q;
    hold_b_mid = (chk_b_short || chk_b_long) ? '0 : hold_b_q;
    hold_a_d   = a_pressed ? count_up(hold_a_mid) : '0;
    hold_b_d   = b_pressed ? count_up(hold_b_mid) : '0;

    out_item_d.press_event   = ev;
    out_item_d.display_run   = run_d;
    out_item_d.display_blank = blank;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_a_q      <= '0;
      hold_b_q      <= '0;
      blink_cnt_q   <= '0;
      blink_phase_q <= 1'b0;
      run_q         <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        hold_a_q      <= hold_a_d;
        hold_b_q      <= hold_b_d;
        blink_cnt_q   <= blink_cnt_d;
        blink_phase_q <= blink_phase_d;
        run_q         <= run_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  // A blank pulse is only produced on entry to blink phase one.
  a_blank_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.display_blank |-> blink_phase_q)
    else $error("display_blank raised outside blink phase one");

  // A released button leaves its hold counter cleared.
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.btn_a_level && in_item_i.btn_b_level
    |=> hold_a_q == '0 && hold_b_q == '0)
    else $error("hold counter not cleared after release");

  // With blink disabled the display keeps running.
  a_blink_off_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_item_i.blink_enable |=> run_q && out_item_o.display_run)
    else $error("display stopped while blink is disabled");

  // An empty output register never stalls the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");
`endif

endmodule
